[hw/rtl/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and codes of the slot allocator with per-pool free stacks.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

   localparam int unsigned NUM_POOLS = 4;
   localparam int unsigned POOL_W    = 2;
   localparam int unsigned SLOT_W    = 16;
   localparam int unsigned CNT_W     = 17;
   localparam int unsigned SIZE_W    = 16;
   localparam int unsigned OFF_W     = 32;
   localparam int unsigned ADDR_W    = 64;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_W     = 64;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [POOL_W-1:0] POOL_RTV     = 2'd0;
   localparam logic [POOL_W-1:0] POOL_DSV     = 2'd1;
   localparam logic [POOL_W-1:0] POOL_VIEW    = 2'd2;
   localparam logic [POOL_W-1:0] POOL_SAMPLER = 2'd3;

   localparam logic [STATUS_W-1:0] ST_GRANTED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_POOL_FULL   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FREED       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREE_IGNORE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_RTV_HOST_BASE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DSV_HOST_BASE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_HOST_BASE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLER_HOST_BASE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_DEVICE_BASE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLER_DEV_BASE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_SIZES       = 3'd6;

   typedef struct packed {
      logic take;
      logic mul_en;
      logic out_en;
   } sfs_cmd_type;

endpackage

`default_nettype wire

[hw/rtl/sfs_ram.sv]
// ----------------------------------------------------------------------------
// sfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/sfs_ctrl.sv]
// ----------------------------------------------------------------------------
// sfs_ctrl
// Request sequencer: accept, stack read and multiply, address add and result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sfs_pkg::sfs_cmd_type    cmd
);

   import sfs_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_ADD  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.take   = 1'b0;
      cmd.mul_en = 1'b0;
      cmd.out_en = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ADD;
         end
         S_ADD: begin
            if (out_free) begin
               cmd.out_en = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.out_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_take_then_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> (req_stall && cmd.mul_en))
      else $error("accepted beat not followed by multiply step");

   a_mul_then_add: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_en |=> (state_ff == S_ADD))
      else $error("multiply step not followed by address step");

   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_en |=> (rsp_valid && state_ff == S_IDLE))
      else $error("result load did not raise valid");

endmodule

`default_nettype wire

[hw/rtl/sfs_dp.sv]
// ----------------------------------------------------------------------------
// sfs_dp
// Datapath: config registers, per-pool counters, free-stack RAMs, address math.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_dp #(
   parameter int unsigned RTV_SLOTS     = 64,
   parameter int unsigned DSV_SLOTS     = 16,
   parameter int unsigned VIEW_SLOTS    = 65536,
   parameter int unsigned SAMPLER_SLOTS = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sfs_pkg::sfs_cmd_type              cmd,
   input  wire logic                              req_command,
   input  wire logic [sfs_pkg::POOL_W-1:0]        req_pool_select,
   input  wire logic [sfs_pkg::SLOT_W-1:0]        req_free_slot,
   input  wire logic                              req_handle_ok,
   input  wire logic                              csr_write_enable,
   input  wire logic [sfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sfs_pkg::CSR_W-1:0]         csr_write_data,
   output logic      [sfs_pkg::STATUS_W-1:0]      rsp_status,
   output logic      [sfs_pkg::SLOT_W-1:0]        rsp_slot,
   output logic      [sfs_pkg::ADDR_W-1:0]        rsp_host_address,
   output logic      [sfs_pkg::ADDR_W-1:0]        rsp_device_address,
   output logic                                   rsp_device_visible
);

   import sfs_pkg::*;

   localparam int unsigned POOL_CAP [NUM_POOLS] =
      '{RTV_SLOTS, DSV_SLOTS, VIEW_SLOTS, SAMPLER_SLOTS};

   // configuration
   logic [ADDR_W-1:0] host_base_ff [NUM_POOLS];
   logic [ADDR_W-1:0] view_dev_base_ff;
   logic [ADDR_W-1:0] smp_dev_base_ff;
   logic [CSR_W-1:0]  entry_sizes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_POOLS; i++) begin
            host_base_ff[i] <= '0;
         end
         view_dev_base_ff <= '0;
         smp_dev_base_ff  <= '0;
         entry_sizes_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RTV_HOST_BASE:     host_base_ff[POOL_RTV]     <= csr_write_data;
            CSR_DSV_HOST_BASE:     host_base_ff[POOL_DSV]     <= csr_write_data;
            CSR_VIEW_HOST_BASE:    host_base_ff[POOL_VIEW]    <= csr_write_data;
            CSR_SAMPLER_HOST_BASE: host_base_ff[POOL_SAMPLER] <= csr_write_data;
            CSR_VIEW_DEVICE_BASE:  view_dev_base_ff           <= csr_write_data;
            CSR_SAMPLER_DEV_BASE:  smp_dev_base_ff            <= csr_write_data;
            CSR_ENTRY_SIZES:       entry_sizes_ff             <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // allocation decision
   logic [CNT_W-1:0] top_ff  [NUM_POOLS];
   logic [CNT_W-1:0] top_in  [NUM_POOLS];
   logic [CNT_W-1:0] bump_ff [NUM_POOLS];
   logic [CNT_W-1:0] bump_in [NUM_POOLS];
   logic [CNT_W-1:0] cur_top, cur_bump, cur_cap;
   logic             do_pop, do_bump, do_push;
   logic [STATUS_W-1:0] dec_status;

   assign cur_top  = top_ff[req_pool_select];
   assign cur_bump = bump_ff[req_pool_select];
   assign cur_cap  = CNT_W'(POOL_CAP[req_pool_select]);

   always_comb begin
      do_pop     = 1'b0;
      do_bump    = 1'b0;
      do_push    = 1'b0;
      dec_status = ST_POOL_FULL;
      if (req_command == CMD_ALLOC) begin
         priority if (cur_top != '0) begin
            do_pop     = 1'b1;
            dec_status = ST_GRANTED;
         end else if (cur_bump < cur_cap) begin
            do_bump    = 1'b1;
            dec_status = ST_GRANTED;
         end else begin
            dec_status = ST_POOL_FULL;
         end
      end else begin
         priority if (!req_handle_ok || ({1'b0, req_free_slot} >= cur_cap)) begin
            dec_status = ST_FREE_IGNORE;
         end else if (cur_top >= cur_cap) begin
            dec_status = ST_STACK_FULL;
         end else begin
            do_push    = 1'b1;
            dec_status = ST_FREED;
         end
      end
   end

   always_comb begin
      top_in  = top_ff;
      bump_in = bump_ff;
      if (cmd.take) begin
         if (do_pop) begin
            top_in[req_pool_select] = cur_top - CNT_W'(1);
         end
         if (do_push) begin
            top_in[req_pool_select] = cur_top + CNT_W'(1);
         end
         if (do_bump) begin
            bump_in[req_pool_select] = cur_bump + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_POOLS; i++) begin
            top_ff[i]  <= '0;
            bump_ff[i] <= '0;
         end
      end else begin
         top_ff  <= top_in;
         bump_ff <= bump_in;
      end
   end

   // free stacks
   logic [SLOT_W-1:0] pop_data [NUM_POOLS];

   for (genvar g = 0; g < NUM_POOLS; g++) begin : g_pool
      localparam int unsigned AW = (POOL_CAP[g] > 1) ? $clog2(POOL_CAP[g]) : 1;
      logic [AW-1:0]    rd_data;
      logic [CNT_W-1:0] pop_addr;
      logic             sel;

      assign sel         = cmd.take && (req_pool_select == POOL_W'(g));
      assign pop_addr    = top_ff[g] - CNT_W'(1);
      assign pop_data[g] = SLOT_W'(rd_data);

      sfs_ram #(
         .WIDTH (AW),
         .DEPTH (POOL_CAP[g])
      ) u_stack (
         .clock   (clock),
         .wr_en   (sel && do_push),
         .wr_addr (top_ff[g][AW-1:0]),
         .wr_data (req_free_slot[AW-1:0]),
         .rd_en   (sel && do_pop),
         .rd_addr (pop_addr[AW-1:0]),
         .rd_data (rd_data)
      );

      a_top_bound: assert property (@(posedge clock) disable iff (reset)
         top_ff[g] <= CNT_W'(POOL_CAP[g]))
         else $error("free stack pointer beyond capacity");

      a_bump_bound: assert property (@(posedge clock) disable iff (reset)
         bump_ff[g] <= CNT_W'(POOL_CAP[g]))
         else $error("bump counter beyond capacity");
   end

   // request stage
   logic [POOL_W-1:0]   pool_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                pop_ff;
   logic [SLOT_W-1:0]   bump_slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pool_ff      <= req_pool_select;
         status_ff    <= dec_status;
         pop_ff       <= do_pop;
         bump_slot_ff <= cur_bump[SLOT_W-1:0];
      end
   end

   // multiply stage
   logic [SLOT_W-1:0] slot_sel, slot_ff;
   logic [SIZE_W-1:0] size_sel;
   logic [OFF_W-1:0]  off_ff;
   logic              granted;

   assign granted  = (status_ff == ST_GRANTED);
   assign size_sel = entry_sizes_ff[SIZE_W*pool_ff +: SIZE_W];

   always_comb begin
      slot_sel = '0;
      if (granted) begin
         slot_sel = pop_ff ? pop_data[pool_ff] : bump_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         slot_ff <= slot_sel;
         off_ff  <= OFF_W'(slot_sel) * OFF_W'(size_sel);
      end
   end

   // address stage and result register
   logic                visible;
   logic [ADDR_W-1:0]   dev_base;
   logic [ADDR_W-1:0]   host_sum, dev_sum;

   assign visible  = (pool_ff == POOL_VIEW) || (pool_ff == POOL_SAMPLER);
   assign dev_base = (pool_ff == POOL_VIEW) ? view_dev_base_ff : smp_dev_base_ff;
   assign host_sum = host_base_ff[pool_ff] + ADDR_W'(off_ff);
   assign dev_sum  = dev_base + ADDR_W'(off_ff);

   always_ff @(posedge clock) begin
      if (cmd.out_en) begin
         rsp_status         <= status_ff;
         rsp_slot           <= slot_ff;
         rsp_host_address   <= granted ? host_sum : '0;
         rsp_device_address <= (granted && visible) ? dev_sum : '0;
         rsp_device_visible <= visible;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/slot_allocator_free_stack_top.sv]
// ----------------------------------------------------------------------------
// slot_allocator_free_stack_top
// Four-pool slot allocator: LIFO free stacks with bump allocation fallback.
// ----------------------------------------------------------------------------
// Each request (allocate or free) returns exactly one result beat. A request
// is accepted in the idle state, the pool's free-stack RAM is read or written
// in that cycle, the slot times entry size product is formed in the next and
// the 64-bit host and device address adds land in the result register in the
// address state after it, once the output is free. A new request is taken in
// the cycle after that, so the block takes no new request while one is in
// flight; the registered stack RAM read, the multiply and the wide add set
// those three steps. A result waiting on rsp_stall holds back the address
// step of the following request only. The free stacks are not cleared after
// reset: the stack pointers alone say which entries hold freed slots. Pool
// capacities are set by the four *_SLOTS parameters (1 to 65536).
// ----------------------------------------------------------------------------
`default_nettype none

module slot_allocator_free_stack_top #(
   parameter int unsigned RTV_SLOTS     = 64,
   parameter int unsigned DSV_SLOTS     = 16,
   parameter int unsigned VIEW_SLOTS    = 65536,
   parameter int unsigned SAMPLER_SLOTS = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_command,
   input  wire logic [sfs_pkg::POOL_W-1:0]        req_pool_select,
   input  wire logic [sfs_pkg::SLOT_W-1:0]        req_free_slot,
   input  wire logic                              req_handle_ok,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [sfs_pkg::STATUS_W-1:0]      rsp_status,
   output logic      [sfs_pkg::SLOT_W-1:0]        rsp_slot,
   output logic      [sfs_pkg::ADDR_W-1:0]        rsp_host_address,
   output logic      [sfs_pkg::ADDR_W-1:0]        rsp_device_address,
   output logic                                   rsp_device_visible,
   input  wire logic                              csr_write_enable,
   input  wire logic [sfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sfs_pkg::CSR_W-1:0]         csr_write_data
);

   import sfs_pkg::*;

   sfs_cmd_type cmd;

   sfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sfs_dp #(
      .RTV_SLOTS     (RTV_SLOTS),
      .DSV_SLOTS     (DSV_SLOTS),
      .VIEW_SLOTS    (VIEW_SLOTS),
      .SAMPLER_SLOTS (SAMPLER_SLOTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_command        (req_command),
      .req_pool_select    (req_pool_select),
      .req_free_slot      (req_free_slot),
      .req_handle_ok      (req_handle_ok),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_host_address   (rsp_host_address),
      .rsp_device_address (rsp_device_address),
      .rsp_device_visible (rsp_device_visible)
   );

endmodule

`default_nettype wire

[tb/slot_allocator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_allocator_checker
// Passive checker for the four-pool slot allocator. It mirrors the CSR writes,
// keeps its own bump counters and free stacks, predicts one result beat per
// accepted request and compares every result beat field by field, in order.
// ----------------------------------------------------------------------------

module slot_allocator_checker #(
   parameter int unsigned RTV_SLOTS     = 64,
   parameter int unsigned DSV_SLOTS     = 16,
   parameter int unsigned VIEW_SLOTS    = 65536,
   parameter int unsigned SAMPLER_SLOTS = 2048
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic                            req_command,
   input  wire logic [sfs_pkg::POOL_W-1:0]      req_pool_select,
   input  wire logic [sfs_pkg::SLOT_W-1:0]      req_free_slot,
   input  wire logic                            req_handle_ok,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [sfs_pkg::STATUS_W-1:0]    rsp_status,
   input  wire logic [sfs_pkg::SLOT_W-1:0]      rsp_slot,
   input  wire logic [sfs_pkg::ADDR_W-1:0]      rsp_host_address,
   input  wire logic [sfs_pkg::ADDR_W-1:0]      rsp_device_address,
   input  wire logic                            rsp_device_visible,
   input  wire logic                            csr_write_enable,
   input  wire logic [sfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sfs_pkg::CSR_W-1:0]       csr_write_data,
   output int                                   mismatches,
   output int                                   results_owed
);
   import sfs_pkg::*;

   localparam int unsigned MAX_DEPTH = 1 << SLOT_W;
   localparam int unsigned MAX_PRINTED = 200;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   host_address;
      logic [ADDR_W-1:0]   device_address;
      logic                device_visible;
   } slot_result_type;

   int unsigned       bump_count [NUM_POOLS];
   int unsigned       stack_depth [NUM_POOLS];
   bit [SLOT_W-1:0]   freed_slots [NUM_POOLS][MAX_DEPTH];
   logic [ADDR_W-1:0] host_base [NUM_POOLS];
   logic [ADDR_W-1:0] view_dev_base;
   logic [ADDR_W-1:0] sampler_dev_base;
   logic [CSR_W-1:0]  entry_sizes;
   slot_result_type   owed_slot_results [$];
   int unsigned       result_beats;

   function automatic int unsigned pool_capacity(input logic [POOL_W-1:0] pool);
      case (pool)
         POOL_RTV:  return RTV_SLOTS;
         POOL_DSV:  return DSV_SLOTS;
         POOL_VIEW: return VIEW_SLOTS;
         default:   return SAMPLER_SLOTS;
      endcase
   endfunction

   // Updates the pool state and returns the beat the request must produce.
   function automatic slot_result_type serve_slot_request(input logic cmd,
                                                          input logic [POOL_W-1:0] pool,
                                                          input logic [SLOT_W-1:0] fslot,
                                                          input logic ok);
      slot_result_type r;
      int unsigned cap;
      logic granted;
      logic [SIZE_W-1:0] size;
      logic [OFF_W-1:0] offset;
      cap = pool_capacity(pool);
      r = '0;
      r.device_visible = (pool == POOL_VIEW) || (pool == POOL_SAMPLER);
      if (cmd == CMD_ALLOC) begin
         granted = 1'b1;
         if (stack_depth[pool] > 0) begin
            stack_depth[pool]--;
            r.slot = freed_slots[pool][stack_depth[pool]];
         end else if (bump_count[pool] < cap) begin
            r.slot = SLOT_W'(bump_count[pool]);
            bump_count[pool]++;
         end else begin
            granted = 1'b0;
         end
         if (granted) begin
            size = entry_sizes[SIZE_W*pool +: SIZE_W];
            offset = r.slot * size;
            r.status = ST_GRANTED;
            r.host_address = host_base[pool] + offset;
            if (pool == POOL_VIEW) begin
               r.device_address = view_dev_base + offset;
            end else if (pool == POOL_SAMPLER) begin
               r.device_address = sampler_dev_base + offset;
            end
         end else begin
            r.status = ST_POOL_FULL;
            r.slot = '0;
         end
      end else begin
         if (!ok || fslot >= cap) begin
            r.status = ST_FREE_IGNORE;
         end else if (stack_depth[pool] >= cap) begin
            r.status = ST_STACK_FULL;
         end else begin
            freed_slots[pool][stack_depth[pool]] = fslot;
            stack_depth[pool]++;
            r.status = ST_FREED;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < MAX_PRINTED) begin
         $display("%0t: result beat %0d: %s mismatch, got 0x%0h, want 0x%0h",
                  $time, result_beats, field, got, want);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      slot_result_type want;
      slot_result_type predicted;
      if (reset) begin
         for (int p = 0; p < NUM_POOLS; p++) begin
            bump_count[p] = 0;
            stack_depth[p] = 0;
            host_base[p] = '0;
         end
         view_dev_base = '0;
         sampler_dev_base = '0;
         entry_sizes = '0;
         owed_slot_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_slot_results.size() == 0) begin
               report_mismatch("unexpected beat, status", rsp_status, '0);
            end else begin
               want = owed_slot_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_slot !== want.slot)
                  report_mismatch("slot", rsp_slot, want.slot);
               if (rsp_host_address !== want.host_address)
                  report_mismatch("host_address", rsp_host_address, want.host_address);
               if (rsp_device_address !== want.device_address)
                  report_mismatch("device_address", rsp_device_address,
                                  want.device_address);
               if (rsp_device_visible !== want.device_visible)
                  report_mismatch("device_visible", rsp_device_visible,
                                  want.device_visible);
            end
            result_beats++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RTV_HOST_BASE:     host_base[POOL_RTV] = csr_write_data;
               CSR_DSV_HOST_BASE:     host_base[POOL_DSV] = csr_write_data;
               CSR_VIEW_HOST_BASE:    host_base[POOL_VIEW] = csr_write_data;
               CSR_SAMPLER_HOST_BASE: host_base[POOL_SAMPLER] = csr_write_data;
               CSR_VIEW_DEVICE_BASE:  view_dev_base = csr_write_data;
               CSR_SAMPLER_DEV_BASE:  sampler_dev_base = csr_write_data;
               CSR_ENTRY_SIZES:       entry_sizes = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted = serve_slot_request(req_command, req_pool_select,
                                           req_free_slot, req_handle_ok);
            owed_slot_results.insert(owed_slot_results.size(), predicted);
         end
      end
      results_owed = owed_slot_results.size();
   end

endmodule

[tb/tb_slot_allocator_free_stack_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_allocator_free_stack_top
// Stimulus and verdict for the four-pool slot allocator. Runs reset-value
// requests, a directed pass over the free and allocate corner cases, a full
// exhaust of the two small pools and their free stacks, then random request
// sequences under sender gaps and result stalls, with CSR settings changed
// between phases. Checking is done by slot_allocator_checker.
// ----------------------------------------------------------------------------

module tb_slot_allocator_free_stack_top;
   import sfs_pkg::*;

   localparam int unsigned RTV_SLOTS     = 64;
   localparam int unsigned DSV_SLOTS     = 16;
   localparam int unsigned VIEW_SLOTS    = 65536;
   localparam int unsigned SAMPLER_SLOTS = 2048;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam logic [CSR_W-1:0] ALL_ONES = '1;
   localparam logic [CSR_W-1:0] ALL_ZEROS = '0;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_command = CMD_ALLOC;
   logic [POOL_W-1:0]    req_pool_select = POOL_RTV;
   logic [SLOT_W-1:0]    req_free_slot = '0;
   logic                 req_handle_ok = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [ADDR_W-1:0]    rsp_host_address;
   logic [ADDR_W-1:0]    rsp_device_address;
   logic                 rsp_device_visible;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatches;
   int results_owed;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   slot_allocator_free_stack_top #(
      .RTV_SLOTS     (RTV_SLOTS),
      .DSV_SLOTS     (DSV_SLOTS),
      .VIEW_SLOTS    (VIEW_SLOTS),
      .SAMPLER_SLOTS (SAMPLER_SLOTS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_pool_select    (req_pool_select),
      .req_free_slot      (req_free_slot),
      .req_handle_ok      (req_handle_ok),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_host_address   (rsp_host_address),
      .rsp_device_address (rsp_device_address),
      .rsp_device_visible (rsp_device_visible),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   slot_allocator_checker #(
      .RTV_SLOTS     (RTV_SLOTS),
      .DSV_SLOTS     (DSV_SLOTS),
      .VIEW_SLOTS    (VIEW_SLOTS),
      .SAMPLER_SLOTS (SAMPLER_SLOTS)
   ) u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_pool_select    (req_pool_select),
      .req_free_slot      (req_free_slot),
      .req_handle_ok      (req_handle_ok),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_host_address   (rsp_host_address),
      .rsp_device_address (rsp_device_address),
      .rsp_device_visible (rsp_device_visible),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatches         (mismatches),
      .results_owed       (results_owed)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   function automatic int unsigned capacity_of(input logic [POOL_W-1:0] pool);
      case (pool)
         POOL_RTV:  return RTV_SLOTS;
         POOL_DSV:  return DSV_SLOTS;
         POOL_VIEW: return VIEW_SLOTS;
         default:   return SAMPLER_SLOTS;
      endcase
   endfunction

   // Holds the beat until accepted; valid stays high for a back-to-back beat.
   task automatic send_request(input logic cmd, input logic [POOL_W-1:0] pool,
                               input logic [SLOT_W-1:0] fslot, input logic ok);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_pool_select <= pool;
      req_free_slot   <= fslot;
      req_handle_ok   <= ok;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic request_alloc(input logic [POOL_W-1:0] pool);
      send_request(CMD_ALLOC, pool, SLOT_W'($urandom), 1'($urandom));
   endtask

   task automatic drain_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
   endtask

   task automatic program_pools(input logic [CSR_W-1:0] rtv_host, dsv_host, view_host,
                                sampler_host, view_dev, sampler_dev, sizes);
      write_csr(CSR_RTV_HOST_BASE, rtv_host);
      write_csr(CSR_DSV_HOST_BASE, dsv_host);
      write_csr(CSR_VIEW_HOST_BASE, view_host);
      write_csr(CSR_SAMPLER_HOST_BASE, sampler_host);
      write_csr(CSR_VIEW_DEVICE_BASE, view_dev);
      write_csr(CSR_SAMPLER_DEV_BASE, sampler_dev);
      write_csr(CSR_ENTRY_SIZES, sizes);
      write_csr(CSR_UNMAPPED, {$urandom, $urandom});
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic program_random_pools;
      program_pools({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom});
   endtask

   // Bump counter to pool full, then free stack to stack full.
   task automatic exhaust_pool(input logic [POOL_W-1:0] pool);
      int unsigned cap;
      cap = capacity_of(pool);
      repeat (cap + 1) request_alloc(pool);
      repeat (cap + 1) send_request(CMD_FREE, pool, SLOT_W'($urandom_range(0, cap - 1)), 1'b1);
   endtask

   task automatic random_traffic(input int unsigned count);
      int unsigned sent;
      int unsigned burst;
      int unsigned kind;
      int unsigned cap;
      logic [POOL_W-1:0] pool;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 39) == 0) drain_results();
         kind  = $urandom_range(0, 9);
         pool  = POOL_W'($urandom_range(0, 3));
         cap   = capacity_of(pool);
         burst = $urandom_range(1, 20);
         if (kind <= 3) begin
            repeat (burst) request_alloc(pool);
            sent += burst;
         end else if (kind <= 6) begin
            repeat (burst)
               send_request(CMD_FREE, pool, SLOT_W'($urandom_range(0, cap - 1)), 1'b1);
            sent += burst;
         end else if (kind == 7) begin
            if (cap <= 65535 && $urandom_range(0, 1) == 1)
               send_request(CMD_FREE, pool, SLOT_W'($urandom_range(cap, 65535)), 1'b1);
            else
               send_request(CMD_FREE, pool, SLOT_W'($urandom), 1'b0);
            sent++;
         end else begin
            send_request(1'($urandom), pool, SLOT_W'($urandom), 1'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      #30_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset-value CSRs: all addresses zero
      request_alloc(POOL_RTV);
      request_alloc(POOL_VIEW);
      drain_results();

      program_pools(64'h0000_1000_0000_0000, 64'h0000_2000_0000_0000,
                    64'hFFFF_FFFF_FFFF_0000, 64'h0000_3000_0000_0040,
                    64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFF0,
                    {16'hFFFF, 16'h0100, 16'h0040, 16'h0020});
      request_alloc(POOL_DSV);
      request_alloc(POOL_VIEW);
      request_alloc(POOL_SAMPLER);
      send_request(CMD_FREE, POOL_RTV, 16'd0, 1'b1);
      send_request(CMD_FREE, POOL_RTV, 16'd0, 1'b1);          // double free
      request_alloc(POOL_RTV);
      request_alloc(POOL_RTV);
      request_alloc(POOL_RTV);
      send_request(CMD_FREE, POOL_RTV, 16'd1, 1'b0);          // bad handle
      send_request(CMD_FREE, POOL_RTV, 16'(RTV_SLOTS), 1'b1); // beyond capacity
      send_request(CMD_FREE, POOL_RTV, 16'(RTV_SLOTS - 1), 1'b1);
      send_request(CMD_FREE, POOL_DSV, 16'(DSV_SLOTS), 1'b1);
      send_request(CMD_FREE, POOL_DSV, 16'(DSV_SLOTS - 1), 1'b1);
      send_request(CMD_FREE, POOL_VIEW, 16'hFFFF, 1'b1);
      send_request(CMD_FREE, POOL_SAMPLER, 16'(SAMPLER_SLOTS), 1'b1);
      send_request(CMD_FREE, POOL_SAMPLER, 16'(SAMPLER_SLOTS - 1), 1'b1);
      send_request(CMD_FREE, POOL_SAMPLER, 16'hFFFF, 1'b1);
      request_alloc(POOL_VIEW);
      request_alloc(POOL_SAMPLER);
      request_alloc(POOL_DSV);
      drain_results();

      program_pools(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      exhaust_pool(POOL_DSV);
      exhaust_pool(POOL_RTV);
      drain_results();

      sender_idle_pct = 61;
      program_pools(ALL_ZEROS, ALL_ZEROS, ALL_ZEROS, ALL_ZEROS, ALL_ZEROS, ALL_ZEROS,
                    ALL_ZEROS);
      random_traffic(170);
      drain_results();

      sender_idle_pct = 0;
      receiver_stall_pct = 61;
      program_random_pools();
      random_traffic(170);
      drain_results();

      sender_idle_pct = 14;
      receiver_stall_pct = 14;
      program_random_pools();
      random_traffic(180);
      drain_results();

      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_ram.sv
hw/rtl/sfs_ctrl.sv
hw/rtl/sfs_dp.sv
hw/rtl/slot_allocator_free_stack_top.sv
tb/slot_allocator_checker.sv
tb/tb_slot_allocator_free_stack_top.sv
